// ===== rtl/core/xytp_pkg.sv =====
`default_nettype none

package xytp_pkg;

    localparam int unsigned COLOR_W = 16;
    localparam int unsigned PIX_W   = 11;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic CMD_LIGHT = 1'b0;
    localparam logic CMD_FADE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_COL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_COL  = 3'd5;

    localparam logic [9:0]  ORIGIN_RST    = 10'd60;
    localparam logic [15:0] LIGHT_COL_RST = 16'hFFFF;
    localparam logic [15:0] FADE_COL_RST  = 16'((2 << 11) + (3 << 5) + 2);

    // controller -> datapath
    typedef struct packed {
        logic load_sample;
        logic load_light;
        logic load_fade;
        logic fade_last;
    } xytp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } xytp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/xy_trace_plotter_with_fade.sv =====
// XY trace plotter with a fading trail.
// Input channel: in_valid/in_stall carry one request of x_sample, y_sample.
// Output channel: out_valid/out_stall carry command requests: one light
// command at the new pixel, then FADE_TAPS fade commands at ring taps spaced
// TRACE_LEN/FADE_TAPS apart starting at the new entry; last marks the final one.
// Config: cfg_we writes cfg_data into the register chosen by cfg_index; the user
// must write only while the block is idle, which the block does not enforce.
// Order: the taken sample is registered (px_reg/py_reg and the ring write),
// then in S_LIGHT the light command is loaded into the output register. The
// controller walks the taps one per cycle while the output register is free,
// bounded by the single read port of the trace ring.
// A new sample is taken as soon as the last fade command sits in the output
// register, even if the receiver has not taken it yet.
// A receiver stall holds the output register and the tap walk in place.
// Reset: config registers take their defaults, the write pointer goes to zero,
// and ring entries not yet written read as pixel (0, 0); no clearing pass.
`default_nettype none

module xy_trace_plotter_with_fade #(
    parameter int unsigned TRACE_LEN = 512,
    parameter int unsigned FADE_TAPS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [xytp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic signed [7:0]             x_sample,
    input  wire logic signed [7:0]             y_sample,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic                          command,
    output      logic signed [10:0]            pixel_x,
    output      logic signed [10:0]            pixel_y,
    output      logic [15:0]                   color,
    output      logic                          last
);

    import xytp_pkg::*;

    xytp_cmd_t    cmd;
    xytp_status_t status;

    xytp_ctrl #(
        .FADE_TAPS (FADE_TAPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    xytp_datapath #(
        .TRACE_LEN (TRACE_LEN),
        .FADE_TAPS (FADE_TAPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .x_sample  (x_sample),
        .y_sample  (y_sample),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .command   (command),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .color     (color),
        .last      (last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/xytp_ram.sv =====
`default_nettype none

module xytp_ram #(
    parameter int unsigned WIDTH = 22,
    parameter int unsigned DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/xytp_ctrl.sv =====
`default_nettype none

module xytp_ctrl #(
    parameter int unsigned FADE_TAPS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire xytp_pkg::xytp_status_t status,
    output      xytp_pkg::xytp_cmd_t    cmd
);

    import xytp_pkg::*;

    localparam int unsigned TW = (FADE_TAPS > 1) ? $clog2(FADE_TAPS) : 1;
    localparam logic [TW-1:0] LAST_TAP = TW'(FADE_TAPS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LIGHT,
        S_FADE
    } state_t;

    state_t        state_reg, state_next;
    logic [TW-1:0] tap_reg, tap_next;

    always_comb
    begin
        state_next      = state_reg;
        tap_next        = tap_reg;
        in_stall        = 1'b1;
        cmd.load_sample = 1'b0;
        cmd.load_light  = 1'b0;
        cmd.load_fade   = 1'b0;
        cmd.fade_last   = (tap_reg == LAST_TAP);
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = S_LIGHT;
                end
            end
            S_LIGHT:
            begin
                if (status.out_free)
                begin
                    cmd.load_light = 1'b1;
                    tap_next       = '0;
                    state_next     = S_FADE;
                end
            end
            S_FADE:
            begin
                if (status.out_free)
                begin
                    cmd.load_fade = 1'b1;
                    if (tap_reg == LAST_TAP)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        tap_next = tap_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/xytp_datapath.sv =====
`default_nettype none

module xytp_datapath #(
    parameter int unsigned TRACE_LEN = 512,
    parameter int unsigned FADE_TAPS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [xytp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data,
    input  wire logic signed [7:0]             x_sample,
    input  wire logic signed [7:0]             y_sample,
    input  wire xytp_pkg::xytp_cmd_t           cmd,
    output      xytp_pkg::xytp_status_t        status,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic                          command,
    output      logic signed [10:0]            pixel_x,
    output      logic signed [10:0]            pixel_y,
    output      logic [15:0]                   color,
    output      logic                          last
);

    import xytp_pkg::*;

    localparam int unsigned PW   = (TRACE_LEN > 1) ? $clog2(TRACE_LEN) : 1;
    localparam int unsigned STEP = TRACE_LEN / FADE_TAPS;
    localparam int unsigned EW   = 2 * PIX_W;

    localparam logic [PW:0]   LEN_W  = (PW + 1)'(TRACE_LEN);
    localparam logic [PW:0]   STEP_W = (PW + 1)'(STEP);
    localparam logic [PW-1:0] PTR_MAX = PW'(TRACE_LEN - 1);

    // signed shift, then clamp to +-64
    function automatic logic signed [7:0] scale_clamp(
        input logic signed [8:0] v,
        input logic signed [4:0] sh
    );
        logic signed [5:0]  nsh;
        logic [3:0]         s;
        logic signed [17:0] wide;
        logic signed [17:0] r;
        nsh  = 6'sd0 - {sh[4], sh};
        if (!sh[4])
        begin
            s = (sh > 5'sd8) ? 4'd8 : sh[3:0];
        end
        else
        begin
            s = (nsh > 6'sd8) ? 4'd8 : nsh[3:0];
        end
        wide = {{9{v[8]}}, v};
        if (!sh[4])
        begin
            r = wide <<< s;
        end
        else
        begin
            r = wide >>> s;
        end
        if (r > 18'sd64)
        begin
            r = 18'sd64;
        end
        else if (r < -18'sd64)
        begin
            r = -18'sd64;
        end
        return r[7:0];
    endfunction

    function automatic logic signed [10:0] place(
        input logic signed [7:0] v,
        input logic [9:0]        origin
    );
        logic signed [11:0] p;
        p = {{4{v[7]}}, v} + {2'b00, origin};
        if (p > 12'sd1023)
        begin
            p = 12'sd1023;
        end
        return p[10:0];
    endfunction

    logic signed [4:0] scale_x_reg, scale_y_reg;
    logic [9:0]        origin_x_reg, origin_y_reg;
    logic [15:0]       light_col_reg, fade_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg   <= '0;
            scale_y_reg   <= '0;
            origin_x_reg  <= ORIGIN_RST;
            origin_y_reg  <= ORIGIN_RST;
            light_col_reg <= LIGHT_COL_RST;
            fade_col_reg  <= FADE_COL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCALE_X:   scale_x_reg   <= cfg_data[4:0];
                REG_SCALE_Y:   scale_y_reg   <= cfg_data[4:0];
                REG_ORIGIN_X:  origin_x_reg  <= cfg_data[9:0];
                REG_ORIGIN_Y:  origin_y_reg  <= cfg_data[9:0];
                REG_LIGHT_COL: light_col_reg <= cfg_data;
                REG_FADE_COL:  fade_col_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    logic signed [8:0]  x_ext, y_neg;
    logic signed [10:0] px_new, py_new;

    assign x_ext  = {x_sample[7], x_sample};
    assign y_neg  = 9'sd0 - {y_sample[7], y_sample};
    assign px_new = place(scale_clamp(x_ext, scale_x_reg), origin_x_reg);
    assign py_new = place(scale_clamp(y_neg, scale_y_reg), origin_y_reg);

    logic signed [10:0] px_reg, py_reg;
    logic [PW-1:0]      wp_reg, idx_reg;
    logic               full_reg;
    logic               tap_valid_reg;

    logic [PW:0]   idx_sum;
    logic [PW-1:0] idx_step;
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    assign idx_sum  = {1'b0, idx_reg} + STEP_W;
    assign idx_step = (idx_sum >= LEN_W) ? PW'(idx_sum - LEN_W) : idx_sum[PW-1:0];
    assign rd_en    = cmd.load_light || (cmd.load_fade && !cmd.fade_last);
    assign rd_addr  = cmd.load_light ? wp_reg : idx_step;

    xytp_ram #(
        .WIDTH (EW),
        .DEPTH (TRACE_LEN)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.load_sample),
        .waddr (wp_reg),
        .wdata ({px_new, py_new}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // entries past the pointer read as zero until the ring first wraps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            full_reg <= 1'b0;
        end
        else if (cmd.load_fade && cmd.fade_last)
        begin
            if (wp_reg == PTR_MAX)
            begin
                wp_reg   <= '0;
                full_reg <= 1'b1;
            end
            else
            begin
                wp_reg <= wp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            px_reg <= px_new;
            py_reg <= py_new;
        end
        if (rd_en)
        begin
            idx_reg       <= rd_addr;
            tap_valid_reg <= full_reg || (rd_addr <= wp_reg);
        end
    end

    logic out_valid_reg;

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_light || cmd.load_fade)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_light)
        begin
            command <= CMD_LIGHT;
            pixel_x <= px_reg;
            pixel_y <= py_reg;
            color   <= light_col_reg;
            last    <= 1'b0;
        end
        else if (cmd.load_fade)
        begin
            command <= CMD_FADE;
            pixel_x <= tap_valid_reg ? rd_data[EW-1:PIX_W] : '0;
            pixel_y <= tap_valid_reg ? rd_data[PIX_W-1:0] : '0;
            color   <= fade_col_reg;
            last    <= cmd.fade_last;
        end
    end

endmodule

`default_nettype wire
